// ----- rtl/skli_pkg.sv -----
`default_nettype none

package skli_pkg;

   localparam int DEFAULT_DEPTH = 1024;
   localparam int KEY_BYTES     = 20;
   localparam int KEY_W         = KEY_BYTES * 8;
   localparam int REC_W         = 31;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [REC_W-1:0] rec_type;

   typedef struct packed {
      key_type key;
      rec_type rec;
   } entry_type;

   // Result of comparing the search key against a stored key.
   typedef struct packed {
      logic equal;
      logic greater;
   } cmp_type;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

endpackage

`default_nettype wire

// ----- rtl/skli_table_ram.sv -----
`default_nettype none

module skli_table_ram
   import skli_pkg::*;
#(
   parameter int  DEPTH  = DEFAULT_DEPTH,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire entry_type         wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      entry_type         rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/skli_key_cmp.sv -----
`default_nettype none

module skli_key_cmp
   import skli_pkg::*;
(
   input  wire key_type search_key,
   input  wire key_type table_key,
   output      cmp_type result
);

   // Byte 0 sits in the top bits, so an unsigned compare gives byte-wise order.
   always_comb begin
      result.equal   = (search_key == table_key);
      result.greater = (search_key > table_key);
   end

endmodule

`default_nettype wire

// ----- rtl/sorted_key_table_insert_lookup_unit.sv -----
`default_nettype none

// Sorted key table with binary-search lookup and ordered insert.
// The request channel carries one transaction per operation: req_tuser selects
// lookup or insert, req_tdata carries the 160-bit key and the record number.
// Every request yields exactly one response transaction with the hit flag, the
// full status and the matched record number.
// A lookup takes at most ceil(log2(entries + 1)) probes; each probe reads the
// table in ST_PROBE and compares in ST_CMP, since the single table memory port
// pair has a registered read. The response is then posted from ST_DONE.
// An insert runs the same search and then moves each later entry up by one
// place at one entry per cycle, writes the new entry in the freed place and
// posts its response. An insert into a full table skips the search and goes
// straight to posting its response with the status flag set.
// req_tready is high only while no operation is in progress. A finished
// response waits in the output register while rsp_tready is low, and the next
// request may already be accepted; its response waits behind the first, with
// req_tready held low. Reset empties the table at once; the memory is not
// cleared, since only entries below the fill count are ever read.

module sorted_key_table_insert_lookup_unit
   import skli_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // key_hi [63:0], key_mid [127:64], key_lo [159:128], record_number [190:160]
   input  wire logic [191:0] req_tdata,
   // opcode [0]
   input  wire logic [0:0]   req_tuser,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // found_record [30:0]
   output      logic [31:0]  rsp_tdata,
   // hit [0], status [1]
   output      logic [1:0]   rsp_tuser
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_SHIFT,
      ST_DONE
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] lo_ff;
   logic [CNT_W-1:0] hi1_ff;   // upper bound plus one
   logic [CNT_W-1:0] mid_ff;
   logic [CNT_W-1:0] pos_ff;
   logic [CNT_W-1:0] sh_ff;
   logic             pend_ff;
   logic [ADDR_W-1:0] pend_addr_ff;
   op_type           op_ff;
   key_type          key_ff;
   rec_type          rec_ff;
   logic             res_hit_ff;
   logic             res_status_ff;
   rec_type          res_rec_ff;
   logic             rsp_tvalid_ff;
   logic             rsp_hit_ff;
   logic             rsp_status_ff;
   rec_type          rsp_rec_ff;

   logic             range_open;
   logic [CNT_W:0]   mid_sum;
   logic [CNT_W-1:0] mid;
   logic [CNT_W-1:0] sh_m1;
   logic             rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type        wr_data;
   entry_type        rd_data;
   cmp_type          cmp;
   logic             req_fire;
   logic             ins_refused;

   skli_table_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   skli_key_cmp u_cmp (
      .search_key (key_ff),
      .table_key  (rd_data.key),
      .result     (cmp)
   );

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign ins_refused = (op_type'(req_tuser[0]) == OP_INSERT) &&
                        (count_ff == CNT_W'(DEPTH));

   always_comb begin
      range_open = (lo_ff < hi1_ff);
      mid_sum    = {1'b0, lo_ff} + {1'b0, hi1_ff} - (CNT_W + 1)'(1);
      mid        = mid_sum[CNT_W:1];
      sh_m1      = sh_ff - CNT_W'(1);
      rd_en      = 1'b0;
      rd_addr    = mid[ADDR_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = pend_addr_ff;
      wr_data    = rd_data;
      unique case (state_ff)
         ST_PROBE: begin
            rd_en = range_open;
         end
         ST_SHIFT: begin
            if (pend_ff) begin
               wr_en = 1'b1;
            end else if (sh_ff == pos_ff) begin
               wr_en       = 1'b1;
               wr_addr     = pos_ff[ADDR_W-1:0];
               wr_data.key = key_ff;
               wr_data.rec = rec_ff;
            end
            if (sh_ff > pos_ff) begin
               rd_en   = 1'b1;
               rd_addr = sh_m1[ADDR_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff         <= op_type'(req_tuser[0]);
                  // Key byte 0 goes to the top bits so the compare is byte-wise.
                  key_ff        <= {req_tdata[63:0], req_tdata[127:64], req_tdata[159:128]};
                  rec_ff        <= req_tdata[190:160];
                  lo_ff         <= '0;
                  hi1_ff        <= count_ff;
                  res_hit_ff    <= 1'b0;
                  res_status_ff <= ins_refused;
                  res_rec_ff    <= '0;
                  if (ins_refused) begin
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_PROBE;
                  end
               end
            end
            ST_PROBE: begin
               mid_ff <= mid;
               if (range_open) begin
                  state_ff <= ST_CMP;
               end else if (op_ff == OP_INSERT) begin
                  pos_ff   <= hi1_ff;
                  sh_ff    <= count_ff;
                  state_ff <= ST_SHIFT;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_CMP: begin
               if (cmp.equal) begin
                  if (op_ff == OP_INSERT) begin
                     // A duplicate key goes right after the matched entry.
                     pos_ff   <= mid_ff + CNT_W'(1);
                     sh_ff    <= count_ff;
                     state_ff <= ST_SHIFT;
                  end else begin
                     res_hit_ff <= 1'b1;
                     res_rec_ff <= rd_data.rec;
                     state_ff   <= ST_DONE;
                  end
               end else begin
                  if (cmp.greater) begin
                     lo_ff <= mid_ff + CNT_W'(1);
                  end else begin
                     hi1_ff <= mid_ff;
                  end
                  state_ff <= ST_PROBE;
               end
            end
            ST_SHIFT: begin
               // Each entry is read and then written one place higher in the next cycle.
               if (sh_ff > pos_ff) begin
                  pend_ff      <= 1'b1;
                  pend_addr_ff <= sh_ff[ADDR_W-1:0];
                  sh_ff        <= sh_m1;
               end else if (pend_ff) begin
                  pend_ff <= 1'b0;
               end else begin
                  count_ff <= count_ff + CNT_W'(1);
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_hit_ff    <= res_hit_ff;
                  rsp_status_ff <= res_status_ff;
                  rsp_rec_ff    <= res_rec_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_rec_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_hit_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds table depth");

   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CNT_W'(wr_addr) <= count_ff) && (count_ff < CNT_W'(DEPTH)))
      else $error("table write outside the filled range");

   a_probe_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (lo_ff <= mid_ff) && (mid_ff < hi1_ff))
      else $error("probe index outside the search bounds");

   a_rsp_posted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && (!rsp_tvalid_ff || rsp_tready) |=>
         rsp_tvalid_ff && (state_ff == ST_IDLE))
      else $error("finished operation did not post a response");

   a_full_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && req_fire && (req_tuser[0] == OP_INSERT) &&
      (count_ff == CNT_W'(DEPTH)) |=> $stable(count_ff) && res_status_ff)
      else $error("insert into a full table changed the table");

endmodule

`default_nettype wire

// ----- bench/tb_sorted_key_table_insert_lookup_unit.sv -----
`default_nettype none

module tb_sorted_key_table_insert_lookup_unit;
   import skli_pkg::*;

   localparam int TABLE_DEPTH   = DEFAULT_DEPTH;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int LONG_HOLD     = 400;
   // A full-table shift plus the search and the output register.
   localparam int TAIL_CYCLES   = 2 * TABLE_DEPTH + 64;
   localparam longint LIMIT_CYCLES = 4 * 2000 * (2 * TABLE_DEPTH + 100);

   typedef struct {
      op_type       op;
      logic [159:0] key;
      logic [30:0]  rec;
      bit           wait_idle;
   } table_req_type;

   typedef struct packed {
      logic        hit;
      logic [30:0] found_record;
      logic        status;
   } table_answer_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   sorted_key_table_insert_lookup_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Shadow copy of the sorted table.
   logic [159:0] tbl_key [TABLE_DEPTH];
   logic [30:0]  tbl_rec [TABLE_DEPTH];
   int           tbl_count = 0;

   table_req_type    req_backlog[$];
   table_answer_type pending_answers[$];
   int               mismatches = 0;

   // Stimulus-side view of the table fill, used to steer key choice and to end the random part.
   logic [159:0] gen_keys[$];
   int           gen_fill = 0;
   int           gen_refused = 0;

   int send_wait = 0;
   bit send_quiet = 0;
   int recv_wait = 0;
   bit recv_quiet = 0;
   int recv_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic table_answer_type predict_table_op(op_type op, logic [159:0] key,
                                                         logic [30:0] rec);
      table_answer_type r;
      int lo, hi, mid, pos;
      bit match;
      r = '0;
      lo = 0;
      hi = tbl_count - 1;
      match = 0;
      pos = 0;
      while (lo <= hi && !match) begin
         mid = (lo + hi) / 2;
         if (key == tbl_key[mid]) begin
            match = 1;
            pos = mid;
         end else if (key > tbl_key[mid]) begin
            lo = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      if (!match) pos = hi + 1;
      if (op == OP_LOOKUP) begin
         if (match) begin
            r.hit = 1'b1;
            r.found_record = tbl_rec[pos];
         end
      end else if (tbl_count >= TABLE_DEPTH) begin
         r.status = 1'b1;
      end else begin
         // A duplicate goes right after the entry that the search landed on.
         if (match) pos++;
         for (int i = tbl_count; i > pos; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_rec[i] = tbl_rec[i-1];
         end
         tbl_key[pos] = key;
         tbl_rec[pos] = rec;
         tbl_count++;
      end
      return r;
   endfunction

   function automatic int draw_gap(inout bit quiet);
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic [159:0] name_key(string s);
      logic [159:0] k;
      k = '0;
      for (int i = 0; i < s.len() && i < 20; i++) k[159-8*i -: 8] = s[i];
      return k;
   endfunction

   function automatic logic [159:0] rand_name_key();
      logic [159:0] k;
      int n;
      k = '0;
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) k[159-8*i -: 8] = 8'($urandom_range(8'h41, 8'h5a));
      // Occasionally leave junk after the terminator.
      if (n < 20 && $urandom_range(0, 3) == 0) k[7:0] = 8'($urandom_range(1, 255));
      return k;
   endfunction

   function automatic logic [159:0] rand_wide_key();
      return {$urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [159:0] pick_known();
      return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
   endfunction

   function automatic logic [159:0] near_known();
      logic [159:0] k;
      k = pick_known();
      case ($urandom_range(0, 2))
         0: k = k + 160'd1;
         1: k = k - 160'd1;
         default: k[$urandom_range(0, 159)] ^= 1'b1;
      endcase
      return k;
   endfunction

   function automatic logic [30:0] rand_record();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return 31'($urandom);
      endcase
   endfunction

   task automatic queue_req(op_type op, logic [159:0] key, logic [30:0] rec, bit wait_idle);
      table_req_type t;
      t.op = op;
      t.key = key;
      t.rec = rec;
      t.wait_idle = wait_idle;
      req_backlog.push_back(t);
      if (op == OP_INSERT) begin
         if (gen_fill < TABLE_DEPTH) begin
            gen_fill++;
            gen_keys.push_back(key);
         end else begin
            gen_refused++;
         end
      end
   endtask

   // Request side.
   always @(posedge clock) begin
      table_req_type cur;
      bit took, offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = 0;
      end else begin
         took = req_tvalid && req_tready;
         offer = req_tvalid && !took;
         if (!offer) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (req_backlog.size() > 0 && (!req_backlog[0].wait_idle
                         || (!took && pending_answers.size() == 0))) begin
               cur = req_backlog.pop_front();
               req_tdata <= {1'b0, cur.rec, cur.key[31:0], cur.key[95:32], cur.key[159:96]};
               req_tuser <= cur.op;
               offer = 1'b1;
               send_wait = draw_gap(send_quiet);
            end
         end
         req_tvalid <= offer;
      end
   end

   // Response side: random back-pressure with two long hold-offs.
   always @(posedge clock) begin
      logic ready;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait = 0;
      end else begin
         ready = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            recv_count++;
            ready = 1'b0;
            recv_wait = draw_gap(recv_quiet);
            if (recv_count == 60 || recv_count == 1300) recv_wait = LONG_HOLD;
         end
         if (!ready) begin
            if (recv_wait > 0) recv_wait--;
            else ready = 1'b1;
         end
         rsp_tready <= ready;
      end
   end

   // Checks each response transaction, then predicts the request accepted at this edge.
   always @(posedge clock) begin
      table_answer_type want, got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.hit = rsp_tuser[0];
            got.status = rsp_tuser[1];
            got.found_record = rsp_tdata[30:0];
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected response hit=%0d record=%0d status=%0d",
                        $time, got.hit, got.found_record, got.status);
               mismatches++;
            end else begin
               want = pending_answers.pop_front();
               if (got !== want) begin
                  $display("%0t: expected hit=%0d record=%0d status=%0d, got hit=%0d record=%0d status=%0d",
                           $time, want.hit, want.found_record, want.status,
                           got.hit, got.found_record, got.status);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_answers.push_back(predict_table_op(op_type'(req_tuser[0]),
               {req_tdata[63:0], req_tdata[127:64], req_tdata[159:128]}, req_tdata[190:160]));
         end
      end
   end

   initial begin
      logic [159:0] k;
      logic [159:0] alpha;
      int sel, n;
      bit is_ins;
      longint spin;

      alpha = name_key("ALPHA");
      // Empty table, then the key extremes.
      queue_req(OP_LOOKUP, '0, '0, 0);
      queue_req(OP_LOOKUP, '1, '0, 0);
      queue_req(OP_INSERT, '0, '0, 0);
      queue_req(OP_INSERT, '1, '1, 0);
      queue_req(OP_LOOKUP, '0, '1, 0);
      queue_req(OP_LOOKUP, '1, '0, 0);
      queue_req(OP_INSERT, '0, 31'd5, 0);
      queue_req(OP_LOOKUP, '0, '0, 0);
      // Names that differ only in a byte after the terminator.
      queue_req(OP_INSERT, alpha, 31'h2AAAAAAA, 0);
      queue_req(OP_INSERT, alpha | 160'h1, 31'h55555555, 0);
      queue_req(OP_LOOKUP, alpha, '0, 0);
      queue_req(OP_LOOKUP, alpha | 160'h1, '0, 0);
      queue_req(OP_LOOKUP, alpha | 160'h2, '0, 0);
      queue_req(OP_INSERT, {64'h0, 64'h8000_0000_0000_0001, 32'h0}, 31'd7, 0);
      queue_req(OP_INSERT, {128'h0, 32'hFFFF_FFFF}, 31'd9, 0);
      queue_req(OP_LOOKUP, {128'h0, 32'hFFFF_FFFF}, '0, 0);
      queue_req(OP_LOOKUP, {128'h0, 32'hFFFF_FFFE}, '0, 0);
      queue_req(OP_LOOKUP, {64'h0, 64'h8000_0000_0000_0001, 32'h0}, '0, 0);
      queue_req(OP_INSERT, '1, 31'd3, 0);
      queue_req(OP_LOOKUP, '1, '0, 0);
      queue_req(OP_LOOKUP, name_key("ZULU"), '0, 1);

      // Random part runs on until it has queued RANDOM_ITEMS requests and the table has filled and refused 30 inserts.
      n = 0;
      while (n < RANDOM_ITEMS || gen_refused < 30) begin
         is_ins = $urandom_range(0, 99) < 65;
         sel = $urandom_range(0, 99);
         if (is_ins) begin
            if (sel < 45) k = rand_name_key();
            else if (sel < 70) k = rand_wide_key();
            else if (sel < 85) k = pick_known();
            else k = near_known();
         end else begin
            if (sel < 50) k = pick_known();
            else if (sel < 70) k = near_known();
            else if (sel < 85) k = rand_name_key();
            else if (sel < 95) k = rand_wide_key();
            else k = sel[0] ? '1 : '0;
         end
         queue_req(is_ins ? OP_INSERT : OP_LOOKUP, k, rand_record(),
                   $urandom_range(0, 149) == 0);
         n++;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      spin = 0;
      do begin
         @(negedge clock);
         spin++;
      end while (!(req_backlog.size() == 0 && !req_tvalid && pending_answers.size() == 0)
                 && spin < LIMIT_CYCLES);

      if (spin >= LIMIT_CYCLES) begin
         $display("FAILURE");
      end else begin
         repeat (TAIL_CYCLES) @(negedge clock);
         if (mismatches == 0) begin
            $display("SUCCESS");
         end else begin
            $display("FAILURE");
         end
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/skli_pkg.sv
rtl/skli_table_ram.sv
rtl/skli_key_cmp.sv
rtl/sorted_key_table_insert_lookup_unit.sv
bench/tb_sorted_key_table_insert_lookup_unit.sv
